/* rtl/hrsp_pkg.sv */
// Shared types, codes and constants for the HTTP request stream parser.
// Used by hrsp_len_acc, hrsp_core and http_request_stream_parser_unit.
package hrsp_pkg;

  localparam int LEN_BITS = 31;
  localparam int KEY_LEN  = 14;
  localparam int IDX_BITS = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    CLS_SEP      = 3'd0,
    CLS_METHOD   = 3'd1,
    CLS_TARGET   = 3'd2,
    CLS_PROTOCOL = 3'd3,
    CLS_NAME     = 3'd4,
    CLS_VALUE    = 3'd5,
    CLS_BODY     = 3'd6
  } token_class_t;

  typedef enum logic [11:0] {
    PH_METHOD_START = 12'b0000_0000_0001,
    PH_METHOD       = 12'b0000_0000_0010,
    PH_TARGET_START = 12'b0000_0000_0100,
    PH_TARGET       = 12'b0000_0000_1000,
    PH_PROTO_START  = 12'b0000_0001_0000,
    PH_PROTO        = 12'b0000_0010_0000,
    PH_PROTO_TAIL   = 12'b0000_0100_0000,
    PH_NAME_START   = 12'b0000_1000_0000,
    PH_NAME         = 12'b0001_0000_0000,
    PH_VALUE_SKIP   = 12'b0010_0000_0000,
    PH_VALUE        = 12'b0100_0000_0000,
    PH_BODY         = 12'b1000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    PARTNER_NONE = 2'd0,
    PARTNER_CR   = 2'd1,
    PARTNER_LF   = 2'd2
  } partner_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    token_class_t        token_class;
    logic                closes_token;
    logic                request_done;
    logic                old_version;
    logic                parse_error;
    logic [LEN_BITS-1:0] body_length;
  } result_t;

  // Lowercase header name that selects the body length.
  function automatic logic [7:0] key_char(input logic [IDX_BITS-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/http_request_stream_parser_unit.sv */
// HTTP request stream parser: tags each byte of a request stream.
// Pipeline: an accepted byte is held in the input register, and its result is loaded into the
// result register when that register moves (it is empty or its result is being taken).
// Throughput: one byte per cycle while out_stall is low, set by the parser state update.
// Reset (rst, synchronous): both pipeline registers empty, parser at the method.
// Depends on hrsp_pkg, hrsp_core and hrsp_len_acc.
module http_request_stream_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic [2:0]                    token_class,
  output logic                          closes_token,
  output logic                          request_done,
  output logic                          old_version,
  output logic                          parse_error,
  output logic [hrsp_pkg::LEN_BITS-1:0] body_length
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;
  logic              in_accept;
  logic              step;
  hrsp_pkg::result_t core_result;
  hrsp_pkg::result_t out_reg;

  // The result register moves whenever it is empty or being taken.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step      = s1_valid && advance;

  hrsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s1_byte),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !advance);
      if (advance) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_byte <= data_byte;
    if (step) out_reg <= core_result;
  end

  assign out_byte     = out_reg.out_byte;
  assign token_class  = out_reg.token_class;
  assign closes_token = out_reg.closes_token;
  assign request_done = out_reg.request_done;
  assign old_version  = out_reg.old_version;
  assign parse_error  = out_reg.parse_error;
  assign body_length  = out_reg.body_length;

`ifndef SYNTH
  a_done_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(request_done && parse_error))
    else $error("request_done and parse_error on the same item");

  a_old_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && old_version) |-> request_done)
    else $error("old_version without request_done");

  a_length_on_separator: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (body_length != '0)) |->
      (token_class == hrsp_pkg::CLS_SEP) && !closes_token && !parse_error)
    else $error("body_length reported on a byte that does not end the headers");

  a_held_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && s1_valid) |-> in_stall)
    else $error("input not stalled while both pipeline registers are full");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(body_length)))
    else $error("stalled result changed");
`endif

endmodule

/* rtl/hrsp_len_acc.sv */
// Decimal length accumulator step: acc * 10 + digit, saturating.
// Depends on hrsp_pkg for the length width.
module hrsp_len_acc (
  input  logic [hrsp_pkg::LEN_BITS-1:0] acc,
  input  logic [3:0]                    digit,
  output logic [hrsp_pkg::LEN_BITS-1:0] acc_next
);

  localparam int WIDE = hrsp_pkg::LEN_BITS + 4;

  logic [WIDE-1:0] acc_wide;
  logic [WIDE-1:0] sum;
  logic [WIDE-1:0] len_max;

  assign acc_wide = {4'b0000, acc};
  assign sum      = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE-4){1'b0}}, digit};
  assign len_max  = {4'b0000, {hrsp_pkg::LEN_BITS{1'b1}}};

  assign acc_next = (sum > len_max) ? {hrsp_pkg::LEN_BITS{1'b1}}
                                    : sum[hrsp_pkg::LEN_BITS-1:0];

endmodule

/* rtl/hrsp_core.sv */
// Parser state and per-byte tagging logic; one byte is consumed per step.
// Depends on hrsp_pkg and hrsp_len_acc.
module hrsp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  output hrsp_pkg::result_t   result
);

  localparam int LB = hrsp_pkg::LEN_BITS;

  hrsp_pkg::phase_t              phase, phase_next;
  hrsp_pkg::partner_t            partner, partner_next;
  logic [LB-1:0]                 acc, acc_next;
  logic [hrsp_pkg::IDX_BITS-1:0] idx, idx_next;
  logic                          still, still_next;
  logic                          is_len, is_len_next;
  logic                          stopped, stopped_next;
  logic                          negative, negative_next;
  logic [LB-1:0]                 remaining, remaining_next;

  logic [LB-1:0] acc_digit;

  hrsp_len_acc u_len_acc (
    .acc      (acc),
    .digit    (data_byte[3:0]),
    .acc_next (acc_digit)
  );

  always_comb begin
    logic [7:0]          c;
    logic [7:0]          lc;
    logic                le;
    logic                ws;
    logic                partner_match;
    logic                err;
    logic                done;
    logic                is_digit;
    logic [LB-1:0]       len;
    logic [LB-1:0]       rem_dec;
    logic [hrsp_pkg::IDX_BITS-1:0] midx;
    logic                mstill;
    logic                first;

    c  = data_byte;
    lc = ((c >= hrsp_pkg::CH_UPPER_A) && (c <= hrsp_pkg::CH_UPPER_Z))
         ? c + hrsp_pkg::CASE_OFFSET : c;
    le = (c == hrsp_pkg::CH_CR) || (c == hrsp_pkg::CH_LF);
    ws = (c == hrsp_pkg::CH_SPACE) || ((c >= hrsp_pkg::CH_TAB) && (c <= hrsp_pkg::CH_CR));
    partner_match = ((partner == hrsp_pkg::PARTNER_CR) && (c == hrsp_pkg::CH_CR)) ||
                    ((partner == hrsp_pkg::PARTNER_LF) && (c == hrsp_pkg::CH_LF));
    is_digit = (c >= hrsp_pkg::CH_ZERO) && (c <= hrsp_pkg::CH_NINE);
    len      = negative ? '0 : acc;
    rem_dec  = (remaining != '0) ? remaining - {{(LB-1){1'b0}}, 1'b1} : remaining;
    first    = (phase == hrsp_pkg::PH_VALUE_SKIP);
    err  = 1'b0;
    done = 1'b0;
    midx   = '0;
    mstill = 1'b1;

    phase_next     = phase;
    partner_next   = hrsp_pkg::PARTNER_NONE;
    acc_next       = acc;
    idx_next       = idx;
    still_next     = still;
    is_len_next    = is_len;
    stopped_next   = stopped;
    negative_next  = negative;
    remaining_next = remaining;

    result.out_byte     = c;
    result.token_class  = hrsp_pkg::CLS_SEP;
    result.closes_token = 1'b0;
    result.request_done = 1'b0;
    result.old_version  = 1'b0;
    result.parse_error  = 1'b0;
    result.body_length  = '0;

    if (!partner_match) begin
      unique case (phase) inside
        hrsp_pkg::PH_METHOD_START: begin
          if (ws) err = 1'b1;
          else begin
            result.token_class = hrsp_pkg::CLS_METHOD;
            phase_next = hrsp_pkg::PH_METHOD;
          end
        end
        hrsp_pkg::PH_METHOD: begin
          if (le) err = 1'b1;
          else if (ws) begin
            result.closes_token = 1'b1;
            phase_next = hrsp_pkg::PH_TARGET_START;
          end else result.token_class = hrsp_pkg::CLS_METHOD;
        end
        hrsp_pkg::PH_TARGET_START: begin
          if (ws) err = 1'b1;
          else begin
            result.token_class = hrsp_pkg::CLS_TARGET;
            phase_next = hrsp_pkg::PH_TARGET;
          end
        end
        hrsp_pkg::PH_TARGET: begin
          if (le) begin
            result.closes_token = 1'b1;
            done = 1'b1;
            result.old_version = 1'b1;
          end else if (ws) begin
            result.closes_token = 1'b1;
            phase_next = hrsp_pkg::PH_PROTO_START;
          end else result.token_class = hrsp_pkg::CLS_TARGET;
        end
        hrsp_pkg::PH_PROTO_START: begin
          if (le) begin
            done = 1'b1;
            result.old_version = 1'b1;
          end else if (ws) err = 1'b1;
          else begin
            result.token_class = hrsp_pkg::CLS_PROTOCOL;
            phase_next = hrsp_pkg::PH_PROTO;
          end
        end
        hrsp_pkg::PH_PROTO: begin
          if (le) begin
            result.closes_token = 1'b1;
            phase_next = hrsp_pkg::PH_NAME_START;
          end else if (ws) begin
            result.closes_token = 1'b1;
            phase_next = hrsp_pkg::PH_PROTO_TAIL;
          end else result.token_class = hrsp_pkg::CLS_PROTOCOL;
        end
        hrsp_pkg::PH_PROTO_TAIL: begin
          if (le) phase_next = hrsp_pkg::PH_NAME_START;
          else if (!ws) err = 1'b1;
        end
        hrsp_pkg::PH_NAME_START: begin
          if (le) begin
            result.body_length = len;
            if (len == '0) done = 1'b1;
            else begin
              remaining_next = len;
              phase_next = hrsp_pkg::PH_BODY;
            end
          end else if (c == hrsp_pkg::CH_COLON) begin
            err = 1'b1;
          end else begin
            // A new name restarts the key comparison at its first character.
            midx   = '0;
            mstill = 1'b1;
            if (lc == hrsp_pkg::key_char(midx)) idx_next = midx + 1'b1;
            else begin
              idx_next   = midx;
              still_next = 1'b0;
            end
            if (lc == hrsp_pkg::key_char(midx)) still_next = mstill;
            result.out_byte    = lc;
            result.token_class = hrsp_pkg::CLS_NAME;
            phase_next = hrsp_pkg::PH_NAME;
          end
        end
        hrsp_pkg::PH_NAME: begin
          if (le) err = 1'b1;
          else if (c == hrsp_pkg::CH_COLON) begin
            result.closes_token = 1'b1;
            if (still && (idx == hrsp_pkg::IDX_BITS'(hrsp_pkg::KEY_LEN))) begin
              is_len_next   = 1'b1;
              acc_next      = '0;
              negative_next = 1'b0;
              stopped_next  = 1'b0;
            end else is_len_next = 1'b0;
            phase_next = hrsp_pkg::PH_VALUE_SKIP;
          end else begin
            if (still && (idx < hrsp_pkg::IDX_BITS'(hrsp_pkg::KEY_LEN)) &&
                (lc == hrsp_pkg::key_char(idx))) idx_next = idx + 1'b1;
            else still_next = 1'b0;
            result.out_byte    = lc;
            result.token_class = hrsp_pkg::CLS_NAME;
          end
        end
        hrsp_pkg::PH_VALUE_SKIP, hrsp_pkg::PH_VALUE: begin
          if (le) begin
            result.closes_token = !first;
            phase_next = hrsp_pkg::PH_NAME_START;
          end else if (!ws || !first) begin
            result.token_class = hrsp_pkg::CLS_VALUE;
            phase_next = hrsp_pkg::PH_VALUE;
            if (is_len && !stopped) begin
              if (is_digit) acc_next = acc_digit;
              else if (first && (c == hrsp_pkg::CH_MINUS)) negative_next = 1'b1;
              else if (!(first && (c == hrsp_pkg::CH_PLUS))) stopped_next = 1'b1;
            end
          end
        end
        hrsp_pkg::PH_BODY: begin
          result.token_class = hrsp_pkg::CLS_BODY;
          remaining_next = rem_dec;
          if (rem_dec == '0) done = 1'b1;
        end
        default: err = 1'b1;
      endcase

      if (err || done) begin
        phase_next     = hrsp_pkg::PH_METHOD_START;
        acc_next       = '0;
        idx_next       = '0;
        still_next     = 1'b1;
        is_len_next    = 1'b0;
        stopped_next   = 1'b0;
        negative_next  = 1'b0;
        remaining_next = '0;
      end
      // A lone line end byte arms the opposite character as its partner.
      if (le && (result.token_class == hrsp_pkg::CLS_SEP))
        partner_next = (c == hrsp_pkg::CH_CR) ? hrsp_pkg::PARTNER_LF : hrsp_pkg::PARTNER_CR;
    end

    result.request_done = done;
    result.parse_error  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= hrsp_pkg::PH_METHOD_START;
      partner   <= hrsp_pkg::PARTNER_NONE;
      acc       <= '0;
      idx       <= '0;
      still     <= 1'b1;
      is_len    <= 1'b0;
      stopped   <= 1'b0;
      negative  <= 1'b0;
      remaining <= '0;
    end else if (step) begin
      phase     <= phase_next;
      partner   <= partner_next;
      acc       <= acc_next;
      idx       <= idx_next;
      still     <= still_next;
      is_len    <= is_len_next;
      stopped   <= stopped_next;
      negative  <= negative_next;
      remaining <= remaining_next;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_request_stream_parser_unit: a byte-level tag predictor,
// a directed table, and random request streams under varied idle and stall mixes.
// Depends on hrsp_pkg and the parser RTL.
module tb_top;
  import hrsp_pkg::*;

  localparam int RANDOM_BYTES = 1920;
  localparam int DIR_ROWS     = 27;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 60;
  localparam int QUIET_LIMIT  = 2000;
  localparam longint unsigned LEN_CAP = (64'd1 << LEN_BITS) - 1;

  typedef struct packed {
    logic [7:0]   data;
    logic         typed;
    token_class_t cls;
    logic         closes;
    logic         done;
    logic         old;
    logic         err;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_byte;
  logic [2:0]          token_class;
  logic                closes_token;
  logic                request_done;
  logic                old_version;
  logic                parse_error;
  logic [LEN_BITS-1:0] body_length;

  http_request_stream_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .token_class  (token_class),
    .closes_token (closes_token),
    .request_done (request_done),
    .old_version  (old_version),
    .parse_error  (parse_error),
    .body_length  (body_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted parser state.
  phase_t              pp_phase;
  partner_t            pp_partner;
  logic [LEN_BITS-1:0] pp_len;
  logic [LEN_BITS-1:0] pp_body_left;
  int unsigned         pp_key_pos;
  bit                  pp_key_ok;
  bit                  pp_len_hdr;
  bit                  pp_digits_done;
  bit                  pp_neg;
  string               length_key = "content-length";

  result_t    tags_due [$];
  logic [7:0] byte_q [$];
  dir_row_t   dir_rows [DIR_ROWS];
  int         gap_pct [4] = '{0, 66, 0, 29};
  int         stall_pct [4] = '{0, 0, 66, 29};
  int         idle_mode = 0;
  int         bytes_in = 0;
  int         fails = 0;
  int         quiet_cycles = 0;
  int         n_done = 0;
  int         n_old = 0;
  int         n_err = 0;
  int         n_bodies = 0;
  longint     max_len = 0;

  function automatic void parser_restart();
    pp_phase       = PH_METHOD_START;
    pp_len         = '0;
    pp_key_pos     = 0;
    pp_key_ok      = 1'b1;
    pp_len_hdr     = 1'b0;
    pp_digits_done = 1'b0;
    pp_neg         = 1'b0;
    pp_body_left   = '0;
  endfunction

  function automatic void key_step(input logic [7:0] c);
    if (pp_key_ok && pp_key_pos < KEY_LEN && c == length_key[pp_key_pos]) begin
      pp_key_pos++;
    end else begin
      pp_key_ok = 1'b0;
    end
  endfunction

  // Decimal parse of a content-length value: optional leading sign, digits up to the first
  // non-digit, saturating at the top of the length range.
  function automatic void value_step(input logic [7:0] c, input bit first);
    longint unsigned acc;
    if (!pp_len_hdr || pp_digits_done) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      acc = 64'(pp_len) * 10 + 64'(c - CH_ZERO);
      pp_len = (acc > LEN_CAP) ? LEN_CAP[LEN_BITS-1:0] : acc[LEN_BITS-1:0];
    end else if (first && c == CH_MINUS) begin
      pp_neg = 1'b1;
    end else if (!(first && c == CH_PLUS)) begin
      pp_digits_done = 1'b1;
    end
  endfunction

  function automatic result_t tag_byte(input logic [7:0] c);
    result_t             r;
    logic [7:0]          lc;
    logic [LEN_BITS-1:0] hdr_len;
    bit                  le;
    bit                  ws;
    bit                  paired;
    r = '0;
    r.out_byte = c;
    r.token_class = CLS_SEP;
    lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    le = (c == CH_CR || c == CH_LF);
    ws = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
    paired = (pp_partner == PARTNER_CR && c == CH_CR) ||
             (pp_partner == PARTNER_LF && c == CH_LF);
    pp_partner = PARTNER_NONE;
    if (!paired) begin
      case (pp_phase)
        PH_METHOD_START: begin
          if (ws) r.parse_error = 1'b1;
          else begin
            r.token_class = CLS_METHOD;
            pp_phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (le) r.parse_error = 1'b1;
          else if (ws) begin
            r.closes_token = 1'b1;
            pp_phase = PH_TARGET_START;
          end else r.token_class = CLS_METHOD;
        end
        PH_TARGET_START: begin
          if (ws) r.parse_error = 1'b1;
          else begin
            r.token_class = CLS_TARGET;
            pp_phase = PH_TARGET;
          end
        end
        PH_TARGET: begin
          if (le) begin
            r.closes_token = 1'b1;
            r.request_done = 1'b1;
            r.old_version = 1'b1;
          end else if (ws) begin
            r.closes_token = 1'b1;
            pp_phase = PH_PROTO_START;
          end else r.token_class = CLS_TARGET;
        end
        PH_PROTO_START: begin
          if (le) begin
            r.request_done = 1'b1;
            r.old_version = 1'b1;
          end else if (ws) r.parse_error = 1'b1;
          else begin
            r.token_class = CLS_PROTOCOL;
            pp_phase = PH_PROTO;
          end
        end
        PH_PROTO: begin
          if (le) begin
            r.closes_token = 1'b1;
            pp_phase = PH_NAME_START;
          end else if (ws) begin
            r.closes_token = 1'b1;
            pp_phase = PH_PROTO_TAIL;
          end else r.token_class = CLS_PROTOCOL;
        end
        PH_PROTO_TAIL: begin
          if (le) pp_phase = PH_NAME_START;
          else if (!ws) r.parse_error = 1'b1;
        end
        PH_NAME_START: begin
          if (le) begin
            hdr_len = pp_neg ? '0 : pp_len;
            r.body_length = hdr_len;
            if (hdr_len == 0) r.request_done = 1'b1;
            else begin
              pp_body_left = hdr_len;
              pp_phase = PH_BODY;
            end
          end else if (c == CH_COLON) r.parse_error = 1'b1;
          else begin
            pp_key_pos = 0;
            pp_key_ok = 1'b1;
            r.out_byte = lc;
            key_step(lc);
            r.token_class = CLS_NAME;
            pp_phase = PH_NAME;
          end
        end
        PH_NAME: begin
          if (le) r.parse_error = 1'b1;
          else if (c == CH_COLON) begin
            r.closes_token = 1'b1;
            if (pp_key_ok && pp_key_pos == KEY_LEN) begin
              pp_len_hdr = 1'b1;
              pp_len = '0;
              pp_neg = 1'b0;
              pp_digits_done = 1'b0;
            end else pp_len_hdr = 1'b0;
            pp_phase = PH_VALUE_SKIP;
          end else begin
            r.out_byte = lc;
            key_step(lc);
            r.token_class = CLS_NAME;
          end
        end
        PH_VALUE_SKIP: begin
          if (le) pp_phase = PH_NAME_START;
          else if (!ws) begin
            r.token_class = CLS_VALUE;
            value_step(c, 1'b1);
            pp_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (le) begin
            r.closes_token = 1'b1;
            pp_phase = PH_NAME_START;
          end else begin
            r.token_class = CLS_VALUE;
            value_step(c, 1'b0);
          end
        end
        PH_BODY: begin
          r.token_class = CLS_BODY;
          if (pp_body_left != 0) pp_body_left--;
          if (pp_body_left == 0) r.request_done = 1'b1;
        end
        default: r.parse_error = 1'b1;
      endcase
      if (r.parse_error || r.request_done) parser_restart();
      // A line end that is not part of a token arms its partner byte.
      if (le && r.token_class == CLS_SEP) pp_partner = (c == CH_CR) ? PARTNER_LF : PARTNER_CR;
    end
    return r;
  endfunction

  function automatic void expect_tag(input result_t r);
    tags_due.push_back(r);
    if (r.request_done) n_done++;
    if (r.old_version) n_old++;
    if (r.parse_error) n_err++;
    if (r.body_length != 0) n_bodies++;
    if (r.body_length > max_len) max_len = r.body_length;
  endfunction

  // Stream generation.
  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] ws_byte(input bit with_le);
    case ($urandom_range(0, with_le ? 5 : 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_tok_byte(input bit no_colon);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || (no_colon && c == CH_COLON));
    return c;
  endfunction

  function automatic void add_line_end(input int kind);
    case (kind)
      0:       byte_q.push_back(CH_CR);
      1:       byte_q.push_back(CH_LF);
      2: begin
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_LF);
      end
      default: begin
        byte_q.push_back(CH_LF);
        byte_q.push_back(CH_CR);
      end
    endcase
  endfunction

  function automatic void add_lead_ws();
    repeat ($urandom_range(0, 2)) byte_q.push_back(ws_byte(1'b0));
  endfunction

  function automatic void add_length_name();
    logic [7:0] c;
    for (int i = 0; i < KEY_LEN; i++) begin
      c = length_key[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - CASE_OFFSET;
      byte_q.push_back(c);
    end
  endfunction

  // One well-formed request with random content. The open-ended one carries a saturating
  // length and only a few body bytes, so it is only used to close the stream.
  function automatic void add_request(input bit open_ended);
    int         le_kind;
    int         n_hdr;
    int         body;
    int         v;
    int         shape;
    logic [7:0] c;
    le_kind = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0:       add_str("GET");
      1:       add_str("POST");
      2:       add_str("HEAD");
      default: repeat ($urandom_range(1, 6)) byte_q.push_back(pick_tok_byte(1'b0));
    endcase
    add_str(" /");
    repeat ($urandom_range(0, 6)) byte_q.push_back(pick_tok_byte(1'b0));
    shape = $urandom_range(0, 9);
    if (!open_ended && shape < 2) begin
      if (shape == 1) add_str(" ");
      add_line_end(le_kind);
      return;
    end
    add_str(" ");
    if ($urandom_range(0, 3) != 0) add_str("HTTP/1.1");
    else repeat ($urandom_range(1, 8)) byte_q.push_back(pick_tok_byte(1'b0));
    repeat ($urandom_range(0, 2)) byte_q.push_back(ws_byte(1'b0));
    add_line_end(le_kind);
    body = 0;
    n_hdr = $urandom_range(0, 4);
    for (int k = 0; k < n_hdr; k++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          add_length_name();
          add_str(":");
          add_lead_ws();
          v = $urandom_range(0, 12);
          case ($urandom_range(0, 6))
            0: add_str($sformatf("+%0d", v));
            1: begin
              add_str($sformatf("-%0d", v));
              v = 0;
            end
            2: add_str($sformatf("%0dx9", v));
            3: add_str($sformatf("00%0d 7", v));
            4: v = 0;
            5: begin
              add_str($sformatf("+-%0d", v));
              v = 0;
            end
            default: add_str($sformatf("%0d", v));
          endcase
          body = v;
        end
        2: begin
          add_str("Content-Lengt");
          if ($urandom_range(0, 1)) add_str("hs");
          add_str(":");
          add_lead_ws();
          add_str("99");
        end
        default: begin
          repeat ($urandom_range(1, 8)) byte_q.push_back(pick_tok_byte(1'b1));
          add_str(":");
          add_lead_ws();
          repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_CR || c == CH_LF);
            byte_q.push_back(c);
          end
        end
      endcase
      add_line_end(le_kind);
    end
    if (open_ended) begin
      add_length_name();
      add_str(": ");
      case ($urandom_range(0, 3))
        0:       add_str("2147483647");
        1:       add_str("2147483648");
        2:       add_str("4294967295");
        default: add_str("99999999999999");
      endcase
      add_line_end(le_kind);
      body = 3;
    end
    add_line_end(le_kind);
    repeat (body) byte_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Broken requests; all but the noise end on a parse error.
  function automatic void add_broken();
    case ($urandom_range(0, 7))
      0: byte_q.push_back(ws_byte(1'b1));
      1: begin
        add_str("GET");
        add_line_end($urandom_range(0, 3));
      end
      2: begin
        add_str("GET ");
        byte_q.push_back(ws_byte(1'b1));
      end
      3: add_str("GET / \t");
      4: begin
        add_str("GET / HTTP/1.1");
        add_line_end($urandom_range(0, 3));
        add_str(":");
      end
      5: begin
        add_str("GET / HTTP/1.1");
        add_line_end($urandom_range(0, 3));
        add_str("Host");
        add_line_end($urandom_range(0, 3));
      end
      6: begin
        add_str("GET / HTTP/1.1 ");
        byte_q.push_back(pick_tok_byte(1'b0));
      end
      default: repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct[idle_mode]) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tags_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint unsigned want_v,
                             input longint unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tags_due.size() == 0) begin
        $error("result with nothing expected: out_byte 0x%0h", out_byte);
        fails++;
      end else begin
        want = tags_due.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("token_class", want.token_class, token_class);
        check_field("closes_token", want.closes_token, closes_token);
        check_field("request_done", want.request_done, request_done);
        check_field("old_version", want.old_version, old_version);
        check_field("parse_error", want.parse_error, parse_error);
        check_field("body_length", want.body_length, body_length);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL http_request_stream_parser_unit");
      $finish;
    end
  end

  // Receiver: random stalls per idle mix, plus one long hold-off while the sender keeps
  // offering, so that the block backs up into its input.
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && bytes_in >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct[idle_mode]);
      end
    end
  end

  initial begin : stimulus
    result_t want;
    int      total;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    parser_restart();
    pp_partner = PARTNER_NONE;
    dir_rows = '{
      // Whitespace where the method must start, then the byte extremes as a method.
      '{CH_SPACE, 1'b1, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b1},
      '{8'h00,    1'b1, CLS_METHOD,   1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF,    1'b1, CLS_METHOD,   1'b0, 1'b0, 1'b0, 1'b0},
      // Line end right after the method; its CR partner is a plain separator.
      '{CH_LF,    1'b1, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b1},
      '{CH_CR,    1'b1, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      // HTTP/0.9 request ended by CRLF right after the target.
      '{"G",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{"/",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{CH_CR,    1'b1, CLS_SEP,      1'b1, 1'b1, 1'b1, 1'b0},
      '{CH_LF,    1'b1, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      // Request line with an empty header section and zero body.
      '{"P",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{"/",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{"H",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{CH_LF,    1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{CH_LF,    1'b1, CLS_SEP,      1'b0, 1'b1, 1'b0, 1'b0},
      // Second space where the protocol must start.
      '{"X",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{"y",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{CH_SPACE, 1'b1, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b1},
      // HTTP/0.9 request with one space between target and line end.
      '{"Q",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{"/",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{" ",      1'b0, CLS_SEP,      1'b0, 1'b0, 1'b0, 1'b0},
      '{CH_LF,    1'b1, CLS_SEP,      1'b0, 1'b1, 1'b1, 1'b0}
    };
    while (byte_q.size() < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) != 0) add_request(1'b0);
      else add_broken();
    end
    add_request(1'b1);
    total = byte_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].data);
      want = tag_byte(dir_rows[i].data);
      if (dir_rows[i].typed) begin
        want.out_byte     = dir_rows[i].data;
        want.token_class  = dir_rows[i].cls;
        want.closes_token = dir_rows[i].closes;
        want.request_done = dir_rows[i].done;
        want.old_version  = dir_rows[i].old;
        want.parse_error  = dir_rows[i].err;
        want.body_length  = '0;
      end
      expect_tag(want);
    end

    for (int i = 0; i < total; i++) begin
      // Each idle mix starts only once every earlier result has come back.
      if (i * 4 / total != idle_mode) begin
        wait_drained();
        idle_mode = i * 4 / total;
      end
      send_byte(byte_q[i]);
      expect_tag(tag_byte(byte_q[i]));
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d bytes over four idle mixes: %0d requests done, %0d HTTP/0.9,",
             bytes_in, n_done, n_old);
    $display("%0d parse errors, %0d headers with a body, longest body length %0d.",
             n_err, n_bodies, max_len);
    if (fails == 0) begin
      $display("PASS http_request_stream_parser_unit");
    end else begin
      $display("FAIL http_request_stream_parser_unit");
    end
    $finish;
  end

endmodule

/* http_request_stream_parser_unit.f */
rtl/hrsp_pkg.sv
rtl/hrsp_len_acc.sv
rtl/hrsp_core.sv
rtl/http_request_stream_parser_unit.sv
verif/tb_top.sv
